@@ hdl/tmcw_pkg.sv @@
// tmcw_pkg: shared constants and types of the text mode console writer
// field widths, character codes, command codes and controller states
// no dependencies
`default_nettype none

package tmcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // transaction field widths
  localparam int COMMAND_W = 3;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COLUMN_W  = 7;
  localparam int LINE_W    = 5;

  // character codes with special meaning
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // attribute of blanks after reset
  localparam logic [ATTR_W-1:0] FILL_RESET = 8'd15;

  // command codes
  typedef enum logic [COMMAND_W-1:0] {
    CMD_PUT_CUR = 3'd0,
    CMD_PUT_POS = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_MOVE    = 3'd4
  } cmd_e;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

@@ hdl/tmcw_if.sv @@
// tmcw_if: command and response channels of the text mode console writer
// valid/ready handshake with payload; uses tmcw_pkg for field widths
`default_nettype none

interface tmcw_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [tmcw_pkg::COMMAND_W-1:0] command;
  logic [tmcw_pkg::CHAR_W-1:0]    char_code;
  logic [tmcw_pkg::ATTR_W-1:0]    attribute;
  logic [tmcw_pkg::COLUMN_W-1:0]  column;
  logic [tmcw_pkg::LINE_W-1:0]    line;

  modport source (output valid, command, char_code, attribute, column, line, input ready);
  modport sink   (input valid, command, char_code, attribute, column, line, output ready);
endinterface

interface tmcw_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tmcw_pkg::COLUMN_W-1:0] cursor_column;
  logic [tmcw_pkg::LINE_W-1:0]   cursor_line;
  logic [tmcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tmcw_pkg::ATTR_W-1:0]   cell_attr;
  logic                          scrolled;

  modport source (output valid, cursor_column, cursor_line, cell_char, cell_attr, scrolled,
                  input ready);
  modport sink   (input valid, cursor_column, cursor_line, cell_char, cell_attr, scrolled,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/tmcw_pos_calc.sv @@
// tmcw_pos_calc: maps a screen column and row to a cell memory address
// the memory holds rows as a ring starting at top_base_i; uses no package
`default_nettype none

module tmcw_pos_calc #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic [$clog2(COLUMNS)-1:0]      col_i,
  input  wire logic [$clog2(ROWS)-1:0]         row_i,
  input  wire logic [$clog2(COLUMNS*ROWS)-1:0] top_base_i,
  output      logic [$clog2(COLUMNS*ROWS)-1:0] addr_o
);

  localparam int TOTAL = COLUMNS * ROWS;
  localparam int AW    = $clog2(TOTAL);

  logic [AW-1:0] row_off;
  logic [AW:0]   sum;

  // row offset from the ring start, wrapped once past the end
  assign row_off = AW'(row_i) * AW'(COLUMNS);
  assign sum     = (AW+1)'(top_base_i) + (AW+1)'(row_off) + (AW+1)'(col_i);
  assign addr_o  = (sum >= (AW+1)'(TOTAL)) ? AW'(sum - (AW+1)'(TOTAL)) : AW'(sum);

endmodule

`default_nettype wire

@@ hdl/text_mode_console_writer_core.sv @@
// text_mode_console_writer_core: text console with cell memory and cursor
// depends on tmcw_pkg, tmcw_if (tmcw_cmd_if, tmcw_rsp_if) and tmcw_pos_calc
//
// Usage:
//   cmd_i carries one command per transaction (put at cursor, put at position,
//   clear, read cell, move cursor); rsp_o returns exactly one response per
//   command with the cursor after it, the read cell and a scroll flag.
//   cfg_we_i/cfg_wdata_i write the fill attribute; write it only while idle.
// Command flow:
//   put, move and unused codes pass through the EXEC and DONE states; a read
//   adds the READ state for the registered memory read. A scroll blanks the
//   bottom row through the single write port in the SWEEP state. A clear sweeps
//   every cell. Rows live in the memory as a ring, so a scroll moves a base
//   pointer instead of cells.
// Reset:
//   the cursor goes to 0 and a clearing pass writes blanks with attribute 15
//   into every cell; cmd_i is not ready meanwhile, configuration writes are
//   taken.
// Stall:
//   a response waits in the output register while the next command is taken
//   and executed; that command completes once the register is free.
`default_nettype none

module text_mode_console_writer_core #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  tmcw_cmd_if.sink                         cmd_i,
  tmcw_rsp_if.source                       rsp_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [tmcw_pkg::ATTR_W-1:0] cfg_wdata_i
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int TOTAL = COLUMNS * ROWS;
  localparam int AW    = $clog2(TOTAL);
  localparam int NW    = $clog2(TOTAL + 1);
  localparam int DW    = tmcw_pkg::ATTR_W + tmcw_pkg::CHAR_W;

  // control state
  tmcw_pkg::state_e state_q, state_d;
  logic [tmcw_pkg::ATTR_W-1:0] fill_q;
  logic [tmcw_pkg::ATTR_W-1:0] blank_attr_q, blank_attr_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [AW-1:0] top_base_q, top_base_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [NW-1:0] sweep_left_q, sweep_left_d;
  logic          sweep_rsp_q, sweep_rsp_d;
  logic          rsp_valid_q, rsp_valid_d;

  // command and result holding registers
  tmcw_pkg::cmd_e              cmd_q;
  logic [tmcw_pkg::CHAR_W-1:0] char_q;
  logic [tmcw_pkg::ATTR_W-1:0] attr_q;
  logic [CW-1:0]               tgt_col_q;
  logic [RW-1:0]               tgt_row_q;
  logic [tmcw_pkg::CHAR_W-1:0] res_char_q, res_char_d;
  logic [tmcw_pkg::ATTR_W-1:0] res_attr_q, res_attr_d;
  logic                        res_scroll_q, res_scroll_d;

  // output payload registers
  logic [tmcw_pkg::COLUMN_W-1:0] out_col_q;
  logic [tmcw_pkg::LINE_W-1:0]   out_row_q;
  logic [tmcw_pkg::CHAR_W-1:0]   out_char_q;
  logic [tmcw_pkg::ATTR_W-1:0]   out_attr_q;
  logic                          out_scroll_q;

  // cell memory
  logic [DW-1:0] mem_q [TOTAL];
  logic [DW-1:0] rd_data_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  // command decode and put arithmetic
  logic                        slot_free, cmd_take, load_rsp;
  logic                        is_put, is_nl, is_bs;
  logic [CW-1:0]               pos_col, put_col, addr_col, sat_col;
  logic [RW-1:0]               pos_row, put_row, addr_row, sat_row;
  logic                        put_we, put_scroll;
  logic [tmcw_pkg::ATTR_W-1:0] attr_eff;
  logic [AW-1:0]               cell_addr;
  logic [AW:0]                 next_base;

  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == tmcw_pkg::ST_IDLE) ||
                       ((state_q == tmcw_pkg::ST_DONE) && slot_free);
  assign cmd_take    = cmd_i.valid && cmd_i.ready;
  assign load_rsp    = (state_q == tmcw_pkg::ST_DONE) && slot_free;

  // saturate the target position on entry
  assign sat_col = (32'(cmd_i.column) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(cmd_i.column);
  assign sat_row = (32'(cmd_i.line) >= ROWS) ? RW'(ROWS - 1) : RW'(cmd_i.line);

  // put position and its cursor step
  assign is_put   = (cmd_q == tmcw_pkg::CMD_PUT_CUR) || (cmd_q == tmcw_pkg::CMD_PUT_POS);
  assign is_nl    = (char_q == tmcw_pkg::CH_NEWLINE);
  assign is_bs    = (char_q == tmcw_pkg::CH_BACKSPACE);
  assign pos_col  = (cmd_q == tmcw_pkg::CMD_PUT_CUR) ? cur_col_q : tgt_col_q;
  assign pos_row  = (cmd_q == tmcw_pkg::CMD_PUT_CUR) ? cur_row_q : tgt_row_q;
  assign attr_eff = (attr_q == '0) ? fill_q : attr_q;

  always_comb begin
    put_col    = pos_col;
    put_row    = pos_row;
    put_we     = 1'b0;
    put_scroll = 1'b0;
    if (is_nl) begin
      put_col = '0;
      if (pos_row == RW'(ROWS - 1)) begin
        put_scroll = 1'b1;
      end else begin
        put_row = pos_row + RW'(1);
      end
    end else if (is_bs) begin
      if (pos_col != '0) begin
        put_col = pos_col - CW'(1);
        put_we  = 1'b1;
      end else if (pos_row != '0) begin
        put_col = CW'(COLUMNS - 1);
        put_row = pos_row - RW'(1);
        put_we  = 1'b1;
      end
    end else begin
      put_we = 1'b1;
      if (pos_col != CW'(COLUMNS - 1)) begin
        put_col = pos_col + CW'(1);
      end else begin
        put_col = '0;
        if (pos_row == RW'(ROWS - 1)) begin
          put_scroll = 1'b1;
        end else begin
          put_row = pos_row + RW'(1);
        end
      end
    end
  end

  // backspace blanks the cell it steps back to
  assign addr_col = (is_put && is_bs) ? put_col : pos_col;
  assign addr_row = (is_put && is_bs) ? put_row : pos_row;

  tmcw_pos_calc #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_pos_calc (
    .col_i      (addr_col),
    .row_i      (addr_row),
    .top_base_i (top_base_q),
    .addr_o     (cell_addr)
  );

  // ring start after a scroll
  assign next_base = ((AW+1)'(top_base_q) + (AW+1)'(COLUMNS) >= (AW+1)'(TOTAL)) ?
                     (AW+1)'(top_base_q) + (AW+1)'(COLUMNS) - (AW+1)'(TOTAL) :
                     (AW+1)'(top_base_q) + (AW+1)'(COLUMNS);

  // memory write port: command writes and blanking sweeps
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = {attr_eff, is_bs ? tmcw_pkg::CH_SPACE : char_q};
    if (state_q == tmcw_pkg::ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_addr_q;
      mem_wdata = {blank_attr_q, tmcw_pkg::CH_SPACE};
    end else if ((state_q == tmcw_pkg::ST_EXEC) && is_put) begin
      mem_we = put_we;
    end
  end

  // controller next state
  always_comb begin
    state_d      = state_q;
    blank_attr_d = blank_attr_q;
    cur_col_d    = cur_col_q;
    cur_row_d    = cur_row_q;
    top_base_d   = top_base_q;
    sweep_addr_d = sweep_addr_q;
    sweep_left_d = sweep_left_q;
    sweep_rsp_d  = sweep_rsp_q;
    res_char_d   = res_char_q;
    res_attr_d   = res_attr_q;
    res_scroll_d = res_scroll_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    case (state_q)
      tmcw_pkg::ST_IDLE: begin
        if (cmd_take) begin
          state_d = tmcw_pkg::ST_EXEC;
        end
      end
      tmcw_pkg::ST_EXEC: begin
        res_char_d   = '0;
        res_attr_d   = '0;
        res_scroll_d = 1'b0;
        blank_attr_d = fill_q;
        state_d      = tmcw_pkg::ST_DONE;
        case (cmd_q)
          tmcw_pkg::CMD_PUT_CUR, tmcw_pkg::CMD_PUT_POS: begin
            cur_col_d = put_col;
            cur_row_d = put_row;
            if (put_scroll) begin
              res_scroll_d = 1'b1;
              top_base_d   = AW'(next_base);
              sweep_addr_d = top_base_q;
              sweep_left_d = NW'(COLUMNS);
              sweep_rsp_d  = 1'b1;
              state_d      = tmcw_pkg::ST_SWEEP;
            end
          end
          tmcw_pkg::CMD_CLEAR: begin
            cur_col_d    = '0;
            cur_row_d    = '0;
            top_base_d   = '0;
            sweep_addr_d = '0;
            sweep_left_d = NW'(TOTAL);
            sweep_rsp_d  = 1'b1;
            state_d      = tmcw_pkg::ST_SWEEP;
          end
          tmcw_pkg::CMD_READ: begin
            state_d = tmcw_pkg::ST_READ;
          end
          tmcw_pkg::CMD_MOVE: begin
            cur_col_d = tgt_col_q;
            cur_row_d = tgt_row_q;
          end
          default: begin
          end
        endcase
      end
      tmcw_pkg::ST_READ: begin
        res_char_d = rd_data_q[tmcw_pkg::CHAR_W-1:0];
        res_attr_d = rd_data_q[DW-1:tmcw_pkg::CHAR_W];
        state_d    = tmcw_pkg::ST_DONE;
      end
      tmcw_pkg::ST_SWEEP: begin
        sweep_addr_d = sweep_addr_q + AW'(1);
        sweep_left_d = sweep_left_q - NW'(1);
        if (sweep_left_q == NW'(1)) begin
          state_d = sweep_rsp_q ? tmcw_pkg::ST_DONE : tmcw_pkg::ST_IDLE;
        end
      end
      tmcw_pkg::ST_DONE: begin
        if (slot_free) begin
          rsp_valid_d = 1'b1;
          state_d     = cmd_take ? tmcw_pkg::ST_EXEC : tmcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tmcw_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers, reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tmcw_pkg::ST_SWEEP;
      fill_q       <= tmcw_pkg::FILL_RESET;
      blank_attr_q <= tmcw_pkg::FILL_RESET;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      top_base_q   <= '0;
      sweep_addr_q <= '0;
      sweep_left_q <= NW'(TOTAL);
      sweep_rsp_q  <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      blank_attr_q <= blank_attr_d;
      cur_col_q    <= cur_col_d;
      cur_row_q    <= cur_row_d;
      top_base_q   <= top_base_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_left_q <= sweep_left_d;
      sweep_rsp_q  <= sweep_rsp_d;
      rsp_valid_q  <= rsp_valid_d;
      if (cfg_we_i) begin
        fill_q <= cfg_wdata_i;
      end
    end
  end

  // command capture and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q     <= tmcw_pkg::cmd_e'(cmd_i.command);
      char_q    <= cmd_i.char_code;
      attr_q    <= cmd_i.attribute;
      tgt_col_q <= sat_col;
      tgt_row_q <= sat_row;
    end
    res_char_q   <= res_char_d;
    res_attr_q   <= res_attr_d;
    res_scroll_q <= res_scroll_d;
    if (load_rsp) begin
      out_col_q    <= tmcw_pkg::COLUMN_W'(cur_col_q);
      out_row_q    <= tmcw_pkg::LINE_W'(cur_row_q);
      out_char_q   <= res_char_q;
      out_attr_q   <= res_attr_q;
      out_scroll_q <= res_scroll_q;
    end
  end

  // cell memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[cell_addr];
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.cursor_column = out_col_q;
  assign rsp_o.cursor_line   = out_row_q;
  assign rsp_o.cell_char     = out_char_q;
  assign rsp_o.cell_attr     = out_attr_q;
  assign rsp_o.scrolled      = out_scroll_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_text_mode_console_writer_core.sv @@
// tb_text_mode_console_writer_core: self-checking bench for the text console writer core
// directed command table, then random command streams under several fill attributes
// depends on tmcw_pkg, tmcw_if and text_mode_console_writer_core

module tb_text_mode_console_writer_core;

  localparam int COLS      = tmcw_pkg::DEF_COLUMNS;
  localparam int NUM_LINES = tmcw_pkg::DEF_ROWS;
  localparam int NUM_CELLS = COLS * NUM_LINES;
  localparam int PHASE_LEN = 150;
  localparam int NUM_DIR   = 25;

  // transaction field widths
  localparam int COMMAND_W = tmcw_pkg::COMMAND_W;
  localparam int CHAR_W    = tmcw_pkg::CHAR_W;
  localparam int ATTR_W    = tmcw_pkg::ATTR_W;
  localparam int COLUMN_W  = tmcw_pkg::COLUMN_W;
  localparam int LINE_W    = tmcw_pkg::LINE_W;

  // command codes the block treats as no-ops
  localparam logic [COMMAND_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [COMMAND_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [COMMAND_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [COMMAND_W-1:0] command;
    logic [CHAR_W-1:0]    char_code;
    logic [ATTR_W-1:0]    attribute;
    logic [COLUMN_W-1:0]  column;
    logic [LINE_W-1:0]    line;
  } cmd_item_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] cursor_column;
    logic [LINE_W-1:0]   cursor_line;
    logic [CHAR_W-1:0]   cell_char;
    logic [ATTR_W-1:0]   cell_attr;
    logic                scrolled;
  } rsp_item_t;

  typedef struct packed {
    cmd_item_t cmd;
    logic      typed;
    rsp_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ATTR_W-1:0] cfg_wdata;

  tmcw_cmd_if cmd_if ();
  tmcw_rsp_if rsp_if ();

  text_mode_console_writer_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_i      (cmd_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // screen image kept by the bench
  logic [15:0]       screen_mem [0:NUM_CELLS-1];
  int unsigned       cursor_pos;
  logic [ATTR_W-1:0] blank_attr;

  rsp_item_t expected_rsp [$];
  int        fault_count;
  int        rsp_seen;
  int        burst_left;

  // directed commands; typed rows carry an expectation read off by hand
  dir_row_t directed_rows [0:NUM_DIR-1] = '{
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd0,   5'd0 },
      1'b1, '{7'd0,  5'd0,  8'd32,  8'd15,  1'b0}},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd127, 5'd31},
      1'b1, '{7'd0,  5'd0,  8'd32,  8'd15,  1'b0}},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd65,  8'd0,   7'd0,   5'd0 },
      1'b1, '{7'd1,  5'd0,  8'd0,   8'd0,   1'b0}},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd0,   5'd0 },
      1'b1, '{7'd1,  5'd0,  8'd65,  8'd15,  1'b0}},
    '{'{tmcw_pkg::CMD_PUT_POS, 8'd255, 8'd255, 7'd127, 5'd31},
      1'b1, '{7'd0,  5'd24, 8'd0,   8'd0,   1'b1}},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd79,  5'd23},
      1'b1, '{7'd0,  5'd24, 8'd255, 8'd255, 1'b0}},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd79,  5'd24},
      1'b1, '{7'd0,  5'd24, 8'd32,  8'd15,  1'b0}},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd8,   8'h5A,  7'd0,   5'd0 }, 1'b0, '0},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd79,  5'd23}, 1'b0, '0},
    '{'{tmcw_pkg::CMD_MOVE,    8'd0,   8'd0,   7'd0,   5'd0 },
      1'b1, '{7'd0,  5'd0,  8'd0,   8'd0,   1'b0}},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd8,   8'd0,   7'd0,   5'd0 },
      1'b1, '{7'd0,  5'd0,  8'd0,   8'd0,   1'b0}},
    '{'{tmcw_pkg::CMD_PUT_POS, 8'd8,   8'h33,  7'd0,   5'd0 },
      1'b1, '{7'd0,  5'd0,  8'd0,   8'd0,   1'b0}},
    '{'{tmcw_pkg::CMD_PUT_POS, 8'd8,   8'd0,   7'd5,   5'd3 }, 1'b0, '0},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd10,  8'd0,   7'd0,   5'd0 }, 1'b0, '0},
    '{'{tmcw_pkg::CMD_MOVE,    8'd0,   8'd0,   7'd10,  5'd24},
      1'b1, '{7'd10, 5'd24, 8'd0,   8'd0,   1'b0}},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd10,  8'd7,   7'd0,   5'd0 }, 1'b0, '0},
    '{'{tmcw_pkg::CMD_PUT_POS, 8'd10,  8'd0,   7'd127, 5'd31}, 1'b0, '0},
    '{'{CMD_SPARE_LO,          8'd0,   8'd0,   7'd0,   5'd0 }, 1'b0, '0},
    '{'{CMD_SPARE_MID,         8'd255, 8'd255, 7'd127, 5'd31}, 1'b0, '0},
    '{'{CMD_SPARE_HI,          8'd65,  8'd1,   7'd3,   5'd2 }, 1'b0, '0},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd0,   8'd1,   7'd0,   5'd0 }, 1'b0, '0},
    '{'{tmcw_pkg::CMD_PUT_CUR, 8'd255, 8'h80,  7'd127, 5'd31}, 1'b0, '0},
    '{'{tmcw_pkg::CMD_CLEAR,   8'd255, 8'd255, 7'd127, 5'd31},
      1'b1, '{7'd0,  5'd0,  8'd0,   8'd0,   1'b0}},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd40,  5'd12},
      1'b1, '{7'd0,  5'd0,  8'd32,  8'd15,  1'b0}},
    '{'{tmcw_pkg::CMD_READ,    8'd0,   8'd0,   7'd79,  5'd24},
      1'b1, '{7'd0,  5'd0,  8'd32,  8'd15,  1'b0}}
  };

  // cell index of a column and line, both saturated to the screen
  function automatic int unsigned cell_of(logic [COLUMN_W-1:0] col, logic [LINE_W-1:0] ln);
    int unsigned c;
    int unsigned l;
    c = (col >= COLS) ? COLS - 1 : col;
    l = (ln >= NUM_LINES) ? NUM_LINES - 1 : ln;
    return l * COLS + c;
  endfunction

  // apply one command to the screen image and form the response
  task automatic console_apply(input cmd_item_t it, output rsp_item_t r);
    int unsigned       idx;
    int unsigned       k;
    logic [ATTR_W-1:0] a;
    logic              did;
    r   = '0;
    did = 1'b0;
    a   = (it.attribute == '0) ? blank_attr : it.attribute;
    case (it.command)
      tmcw_pkg::CMD_PUT_CUR, tmcw_pkg::CMD_PUT_POS: begin
        idx = (it.command == tmcw_pkg::CMD_PUT_CUR) ? cursor_pos
                                                    : cell_of(it.column, it.line);
        if (it.char_code == tmcw_pkg::CH_NEWLINE) begin
          idx = (idx / COLS + 1) * COLS;
        end else if (it.char_code == tmcw_pkg::CH_BACKSPACE) begin
          // nothing is blanked at the first cell
          if (idx >= 1) begin
            idx = idx - 1;
            screen_mem[idx] = {a, tmcw_pkg::CH_SPACE};
          end
        end else begin
          screen_mem[idx] = {a, it.char_code};
          idx = idx + 1;
        end
        // ran past the last cell: scroll up one row
        if (idx >= NUM_CELLS) begin
          for (k = 0; k < NUM_CELLS - COLS; k++) screen_mem[k] = screen_mem[k + COLS];
          for (k = NUM_CELLS - COLS; k < NUM_CELLS; k++)
            screen_mem[k] = {blank_attr, tmcw_pkg::CH_SPACE};
          did = 1'b1;
          idx = idx - COLS;
        end
        cursor_pos = idx;
      end
      tmcw_pkg::CMD_CLEAR: begin
        for (k = 0; k < NUM_CELLS; k++) screen_mem[k] = {blank_attr, tmcw_pkg::CH_SPACE};
        cursor_pos = 0;
      end
      tmcw_pkg::CMD_READ: begin
        idx = cell_of(it.column, it.line);
        r.cell_char = screen_mem[idx][7:0];
        r.cell_attr = screen_mem[idx][15:8];
      end
      tmcw_pkg::CMD_MOVE: begin
        cursor_pos = cell_of(it.column, it.line);
      end
      default: begin
      end
    endcase
    r.cursor_column = COLUMN_W'(cursor_pos % COLS);
    r.cursor_line   = LINE_W'(cursor_pos / COLS);
    r.scrolled      = did;
  endtask

  // random command, mostly text at the cursor, biased toward the bottom row
  function automatic cmd_item_t random_cmd();
    cmd_item_t   it;
    int unsigned pick;
    int unsigned ch_pick;
    pick    = $urandom_range(0, 999);
    ch_pick = $urandom_range(0, 9);
    if (ch_pick == 0) it.char_code = tmcw_pkg::CH_NEWLINE;
    else if (ch_pick == 1) it.char_code = tmcw_pkg::CH_BACKSPACE;
    else it.char_code = CHAR_W'($urandom_range(0, 255));
    it.attribute = ($urandom_range(0, 4) == 0) ? '0 : ATTR_W'($urandom_range(0, 255));
    it.column = ($urandom_range(0, 3) != 0) ? COLUMN_W'($urandom_range(0, COLS - 1))
                                            : COLUMN_W'($urandom_range(0, 127));
    it.line = ($urandom_range(0, 3) != 0) ? LINE_W'($urandom_range(0, NUM_LINES - 1))
                                          : LINE_W'($urandom_range(0, 31));
    if ($urandom_range(0, 2) == 0) it.line = LINE_W'(NUM_LINES - 1);
    if (pick < 8) it.command = tmcw_pkg::CMD_CLEAR;
    else if (pick < 560) it.command = tmcw_pkg::CMD_PUT_CUR;
    else if (pick < 690) it.command = tmcw_pkg::CMD_PUT_POS;
    else if (pick < 850) it.command = tmcw_pkg::CMD_READ;
    else if (pick < 950) it.command = tmcw_pkg::CMD_MOVE;
    else it.command = COMMAND_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    return it;
  endfunction

  // offer one command, record its expectation, then idle between bursts
  task automatic send_cmd(input cmd_item_t it, input logic typed, input rsp_item_t want);
    rsp_item_t predicted;
    int        gap;
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= it.command;
    cmd_if.char_code <= it.char_code;
    cmd_if.attribute <= it.attribute;
    cmd_if.column    <= it.column;
    cmd_if.line      <= it.line;
    do @(posedge clk); while (!cmd_if.ready);
    console_apply(it, predicted);
    expected_rsp.push_back(typed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every response is back
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_fill(input logic [ATTR_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    blank_attr = v;
  endtask

  // command side: reset, directed table, then random phases
  initial begin : stimulus
    int                ph;
    int                n;
    logic [ATTR_W-1:0] fill;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    cmd_if.valid     <= 1'b0;
    cmd_if.command   <= '0;
    cmd_if.char_code <= '0;
    cmd_if.attribute <= '0;
    cmd_if.column    <= '0;
    cmd_if.line      <= '0;
    blank_attr = tmcw_pkg::FILL_RESET;
    cursor_pos = 0;
    burst_left = 0;
    for (n = 0; n < NUM_CELLS; n++) screen_mem[n] = {tmcw_pkg::FILL_RESET, tmcw_pkg::CH_SPACE};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

    for (ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: fill = '0;
        1: fill = '1;
        3: fill = 8'h80;
        default: fill = ATTR_W'($urandom_range(1, 254));
      endcase
      write_fill(fill);
      for (n = 0; n < PHASE_LEN; n++) begin
        // one full pause until the block has answered everything
        if (ph == 2 && n == 60) settle();
        send_cmd(random_cmd(), 1'b0, '0);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (fault_count == 0) begin
      $display("text_mode_console_writer_core test passed");
    end else begin
      $display("text_mode_console_writer_core test failed");
    end
    $finish;
  end

  // response side: stall pattern plus one long hold-off
  initial begin : rsp_drain
    int seg_left;
    int stall_mode;
    int hold_left;
    bit long_done;
    seg_left  = 0;
    stall_mode = 0;
    hold_left = 0;
    long_done = 1'b0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!long_done && rsp_seen >= 250) begin
        long_done = 1'b1;
        hold_left = 400;
        rsp_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left   = $urandom_range(4, 40);
          stall_mode = $urandom_range(0, 2);
        end
        seg_left--;
        case (stall_mode)
          0: rsp_if.ready <= 1'b1;
          1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
          default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // compare each response transaction with the oldest expectation
  always @(posedge clk) begin : rsp_check
    rsp_item_t got;
    rsp_item_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.cursor_column, rsp_if.cursor_line, rsp_if.cell_char,
              rsp_if.cell_attr, rsp_if.scrolled};
      rsp_seen++;
      if (expected_rsp.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected response %0d: col %0d line %0d char %0d attr %0d scr %0b",
                   rsp_seen, got.cursor_column, got.cursor_line, got.cell_char,
                   got.cell_attr, got.scrolled);
        fault_count++;
      end else begin
        want = expected_rsp.pop_front();
        if (got.cursor_column !== want.cursor_column || got.cursor_line !== want.cursor_line ||
            got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
            got.scrolled !== want.scrolled) begin
          if (fault_count < 10) begin
            $display("response %0d: expected col %0d line %0d char %0d attr %0d scr %0b",
                     rsp_seen, want.cursor_column, want.cursor_line, want.cell_char,
                     want.cell_attr, want.scrolled);
            $display("response %0d: got      col %0d line %0d char %0d attr %0d scr %0b",
                     rsp_seen, got.cursor_column, got.cursor_line, got.cell_char,
                     got.cell_attr, got.scrolled);
          end
          fault_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    fault_count = 0;
    rsp_seen    = 0;
    #2000000;
    $display("text_mode_console_writer_core test failed");
    $finish;
  end

endmodule
